// ----- hdl/akvt_pkg.sv -----
package akvt_pkg;

	// Request codes as they arrive in req_type
	typedef enum logic [1:0] {
		OP_SET    = 2'd0,
		OP_GET    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_LIST   = 2'd3
	} op_t;

	// Result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	localparam int FIELD_BITS = 64;
	localparam int TIME_BITS  = 32;
	localparam int COUNT_BITS = 5;

	localparam logic [TIME_BITS-1:0] TTL_RESET = 32'd60;

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Classified request as it travels from front to back
	typedef struct packed {
		op_t                   op;
		logic [FIELD_BITS-1:0] key;
		logic [FIELD_BITS-1:0] value;
		logic [TIME_BITS-1:0]  now;
		logic [TIME_BITS-1:0]  expiry;
	} cmd_t;

endpackage

// ----- hdl/akvt_if.sv -----
// Request channel
interface akvt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [63:0] key;
	logic [63:0] value;
	logic [31:0] now;

	modport source (output valid, req_type, key, value, now, input ready);
	modport sink   (input valid, req_type, key, value, now, output ready);
endinterface

// Result channel
interface akvt_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [63:0] found_value;
	logic [63:0] listed_key;
	logic [4:0]  entry_count;
	logic        last;

	modport source (output valid, status, found_value, listed_key, entry_count, last,
		input ready);
	modport sink   (input valid, status, found_value, listed_key, entry_count, last,
		output ready);
endinterface

// ----- hdl/akvt_front.sv -----
module akvt_front #(
	parameter int KEY_BITS   = 64,
	parameter int VALUE_BITS = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	akvt_req_if.sink        req,
	input  logic            cfg_we,
	input  logic [31:0]     cfg_wdata,
	output logic            cmd_valid,
	input  logic            cmd_ready,
	output akvt_pkg::cmd_t  cmd
);
	import akvt_pkg::*;

	localparam logic [FIELD_BITS-1:0] KEY_MASK   = {FIELD_BITS{1'b1}} >> (FIELD_BITS - KEY_BITS);
	localparam logic [FIELD_BITS-1:0] VALUE_MASK =
		{FIELD_BITS{1'b1}} >> (FIELD_BITS - VALUE_BITS);

	logic [TIME_BITS-1:0] ttl_q;
	logic                 vld_s1;
	cmd_t                 cmd_s1;
	logic [TIME_BITS:0]   exp_sum;
	cmd_t                 cmd_nxt;
	logic                 take;

	// ttl register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ttl_q <= TTL_RESET;
		end else if (cfg_we) begin
			ttl_q <= cfg_wdata;
		end
	end

	// Classify: mask words to stored widths, stamp saturated expiry
	always_comb begin
		exp_sum        = {1'b0, req.now} + {1'b0, ttl_q};
		cmd_nxt.op     = op_t'(req.req_type);
		cmd_nxt.key    = req.key & KEY_MASK;
		cmd_nxt.value  = req.value & VALUE_MASK;
		cmd_nxt.now    = req.now;
		cmd_nxt.expiry = exp_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : exp_sum[TIME_BITS-1:0];
	end

	assign req.ready = !vld_s1 || cmd_ready;
	assign take      = req.valid && req.ready;

	// Holding stage in front of the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (cmd_ready) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd_nxt;
		end
	end

	assign cmd_valid = vld_s1;
	assign cmd       = cmd_s1;

endmodule

// ----- hdl/akvt_queue.sv -----
module akvt_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  akvt_pkg::cmd_t  push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output akvt_pkg::cmd_t  pop_data
);
	import akvt_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [FW-1:0] fill_q;
	logic          push;
	logic          pop;

	assign push_ready = fill_q != FW'(QUEUE_DEPTH);
	assign pop_valid  = fill_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = slot_q[rd_ptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- hdl/akvt_engine.sv -----
module akvt_engine #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 64,
	parameter int VALUE_BITS = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	input  akvt_pkg::cmd_t  cmd,
	akvt_rsp_if.source      rsp
);
	import akvt_pkg::*;

	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int VAL_LSB = KEY_BITS;
	localparam int EXP_LSB = KEY_BITS + VALUE_BITS;
	localparam int EW      = EXP_LSB + TIME_BITS;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DEC  = 4'd1;
	localparam logic [3:0] S_RD   = 4'd2;
	localparam logic [3:0] S_CHK  = 4'd3;
	localparam logic [3:0] S_SHR  = 4'd4;
	localparam logic [3:0] S_SHW  = 4'd5;
	localparam logic [3:0] S_LRD  = 4'd6;
	localparam logic [3:0] S_LOUT = 4'd7;
	localparam logic [3:0] S_EMIT = 4'd8;

	logic [EW-1:0]         mem [ENTRIES];
	logic [EW-1:0]         rd_q;
	logic [AW-1:0]         rd_addr;
	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	logic [EW-1:0]         mem_wdata;

	logic [3:0]            state_q;
	cmd_t                  cmd_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [CNT_W-1:0]      idx_q;
	logic [CNT_W-1:0]      jdx_q;
	logic [CNT_W-1:0]      idx_nxt;
	logic [CNT_W-1:0]      jdx_nxt;
	logic                  drop_match_q;
	logic [1:0]            res_status_q;
	logic [FIELD_BITS-1:0] res_value_q;

	logic                  out_vld_q;
	logic [1:0]            out_status_q;
	logic [FIELD_BITS-1:0] out_value_q;
	logic [FIELD_BITS-1:0] out_key_q;
	logic [COUNT_BITS-1:0] out_count_q;
	logic                  out_last_q;
	logic                  out_free;
	logic                  out_load;

	logic [KEY_BITS-1:0]   rd_key;
	logic [VALUE_BITS-1:0] rd_val;
	logic [TIME_BITS-1:0]  rd_exp;
	logic                  scan_end;
	logic                  expired;
	logic                  match;

	assign rd_key   = rd_q[KEY_BITS-1:0];
	assign rd_val   = rd_q[VAL_LSB +: VALUE_BITS];
	assign rd_exp   = rd_q[EXP_LSB +: TIME_BITS];
	assign idx_nxt  = idx_q + 1'b1;
	assign jdx_nxt  = jdx_q + 1'b1;
	assign scan_end = idx_q >= cnt_q;
	assign expired  = rd_exp < cmd_q.now;
	assign match    = rd_key == cmd_q.key[KEY_BITS-1:0];
	assign out_free = !out_vld_q || rsp.ready;
	assign out_load = out_free && (state_q == S_LOUT || state_q == S_EMIT);

	assign cmd_ready = state_q == S_IDLE;

	// Table port: read address and write side
	always_comb begin
		rd_addr   = (state_q == S_SHR) ? jdx_nxt[AW-1:0] : idx_q[AW-1:0];
		mem_we    = 1'b0;
		mem_waddr = idx_q[AW-1:0];
		mem_wdata = {cmd_q.expiry, cmd_q.value[VALUE_BITS-1:0], cmd_q.key[KEY_BITS-1:0]};
		if (state_q == S_RD && scan_end && cmd_q.op == OP_SET) begin
			// append at the end of the packed table
			mem_we    = 1'b1;
			mem_waddr = cnt_q[AW-1:0];
		end else if (state_q == S_CHK && !expired && match && cmd_q.op == OP_SET) begin
			mem_we = 1'b1;
		end else if (state_q == S_SHW) begin
			// move one entry down during compaction
			mem_we    = 1'b1;
			mem_waddr = jdx_q[AW-1:0];
			mem_wdata = rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[rd_addr];
	end

	// Result register valid: load wins over a drain in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			idx_q        <= '0;
			jdx_q        <= '0;
			drop_match_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q   <= cmd;
						idx_q   <= '0;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					res_value_q <= '0;
					if (cmd_q.op == OP_LIST) begin
						if (cnt_q == '0) begin
							res_status_q <= ST_OK;
							state_q      <= S_EMIT;
						end else begin
							state_q <= S_LRD;
						end
					end else if (cmd_q.op == OP_SET && cnt_q >= CNT_W'(ENTRIES)) begin
						res_status_q <= ST_FULL;
						state_q      <= S_EMIT;
					end else begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					if (scan_end) begin
						if (cmd_q.op == OP_SET) begin
							cnt_q        <= cnt_q + 1'b1;
							res_status_q <= ST_OK;
						end else begin
							res_status_q <= ST_NOT_FOUND;
						end
						state_q <= S_EMIT;
					end else begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (expired) begin
						// age out this slot, then look at it again
						jdx_q        <= idx_q;
						drop_match_q <= 1'b0;
						state_q      <= S_SHR;
					end else if (match) begin
						unique case (cmd_q.op)
							OP_GET: begin
								res_status_q <= ST_OK;
								res_value_q  <= FIELD_BITS'(rd_val);
								state_q      <= S_EMIT;
							end
							OP_SET: begin
								res_status_q <= ST_OK;
								state_q      <= S_EMIT;
							end
							OP_REMOVE: begin
								jdx_q        <= idx_q;
								drop_match_q <= 1'b1;
								state_q      <= S_SHR;
							end
							OP_LIST: begin
								state_q <= S_IDLE;
							end
						endcase
					end else begin
						idx_q   <= idx_nxt;
						state_q <= S_RD;
					end
				end
				S_SHR: begin
					if (jdx_nxt < cnt_q) begin
						state_q <= S_SHW;
					end else begin
						cnt_q <= cnt_q - 1'b1;
						if (drop_match_q) begin
							res_status_q <= ST_OK;
							state_q      <= S_EMIT;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_SHW: begin
					jdx_q   <= jdx_nxt;
					state_q <= S_SHR;
				end
				S_LRD: begin
					state_q <= S_LOUT;
				end
				S_LOUT: begin
					if (out_free) begin
						out_status_q <= ST_OK;
						out_value_q  <= '0;
						out_key_q    <= FIELD_BITS'(rd_key);
						out_count_q  <= COUNT_BITS'(cnt_q);
						out_last_q   <= idx_nxt == cnt_q;
						idx_q        <= idx_nxt;
						state_q      <= (idx_nxt == cnt_q) ? S_IDLE : S_LRD;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_status_q <= res_status_q;
						out_value_q  <= res_value_q;
						out_key_q    <= '0;
						out_count_q  <= COUNT_BITS'(cnt_q);
						out_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.status      = out_status_q;
	assign rsp.found_value = out_value_q;
	assign rsp.listed_key  = out_key_q;
	assign rsp.entry_count = out_count_q;
	assign rsp.last        = out_last_q;

	// Checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(ENTRIES))
		else $error("entry count above capacity");

	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHW) |-> (jdx_nxt < cnt_q))
		else $error("compaction moves an entry from beyond the table");

	a_cnt_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_SHR) |=> (cnt_q >= $past(cnt_q)))
		else $error("entry count fell outside compaction");

	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD && scan_end && cmd_q.op == OP_SET) |-> (cnt_q < CNT_W'(ENTRIES)))
		else $error("append into a full table");

endmodule

// ----- hdl/aging_key_value_table_unit.sv -----
// Channel   Dir  Handshake       Payload
// req       in   valid / ready   req_type, key, value, now
// rsp       out  valid / ready   status, found_value, listed_key, entry_count, last
// cfg       in   cfg_we          cfg_wdata (ttl)
//
// Get, set and remove check the stored slots in turn and move later entries down
// when a slot is aged out or removed; the table memory has one read and one write
// per cycle. List gives one result per stored key. A full-table set skips the scan.
// Reset clears the entry count and loads ttl with 60; table contents are not cleared.
// Requests queue in front of the table while it works; a stalled result holds the
// table sequencer, and the request channel once the queue and front stage fill.
module aging_key_value_table_unit #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 64,
	parameter int VALUE_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	akvt_req_if.sink    req,
	akvt_rsp_if.source  rsp,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);
	import akvt_pkg::*;

	logic fr_valid;
	logic fr_ready;
	cmd_t fr_cmd;
	logic bk_valid;
	logic bk_ready;
	cmd_t bk_cmd;

	// Front: accept and classify
	akvt_front #(
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd_valid (fr_valid),
		.cmd_ready (fr_ready),
		.cmd       (fr_cmd)
	);

	// Command queue
	akvt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_data  (fr_cmd),
		.pop_valid  (bk_valid),
		.pop_ready  (bk_ready),
		.pop_data   (bk_cmd)
	);

	// Back: table scan, aging and results
	akvt_engine #(
		.ENTRIES    (ENTRIES),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (bk_valid),
		.cmd_ready (bk_ready),
		.cmd       (bk_cmd),
		.rsp       (rsp)
	);

endmodule
